[sv/damped_spring_force_macros.svh]
// ----------------------------------------------------------------------------
// damped spring force assertion macros
// shared property shorthands for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_MACROS_SVH
`define DAMPED_SPRING_FORCE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DSF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DSF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dsf_pkg.sv]
// ----------------------------------------------------------------------------
// dsf_pkg
// widths, register codes and word types of the damped spring force block
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int ADDR_W    = 4;
    localparam int DMAG_W    = W + 1;            // |pos a - pos b|
    localparam int SQ_W      = 2 * DMAG_W;       // sum of squares
    localparam int LEN_W     = DMAG_W + 1;       // floor sqrt of sum
    localparam int STR_W     = LEN_W + 1;        // signed stretch
    localparam int RAD_W     = 2 * LEN_W;        // padded radicand
    localparam int REM_W     = LEN_W + 4;        // sqrt remainder
    localparam int MA_W      = SQ_W;             // multiplicand
    localparam int MB_W      = DMAG_W;           // multiplier
    localparam int MP_W      = MA_W + MB_W;      // product
    localparam int DEN_W     = LEN_W + FRAC_BITS;
    localparam int TERM_W    = 64;
    localparam int MAG_W     = 63;

    localparam logic [MAG_W-1:0] TERM_CLAMP = {1'b1, {(MAG_W-1){1'b0}}};

    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_REST_LEN  = 2'd1;
    localparam logic [1:0] REG_DAMPING   = 2'd2;

    typedef struct packed {
        logic [2:0][W-1:0] pos;
        logic [2:0][W-1:0] vel;
        logic [W-1:0]      mass;
    } t_endpoint;

    typedef struct packed {
        t_endpoint e0;
        t_endpoint e1;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qflags;

    typedef struct packed {
        logic [W-1:0] stiffness;
        logic [W-1:0] rest_len;
        logic [W-1:0] damping;
    } t_cfg;

    typedef struct packed {
        logic [W-1:0] fx;
        logic [W-1:0] fy;
        logic [W-1:0] fz;
        logic         second;
    } t_result;

endpackage

[sv/damped_spring_force.sv]
// ----------------------------------------------------------------------------
// damped_spring_force
// damped hooke spring force between two endpoints, fixed point q16.16
// ----------------------------------------------------------------------------
//
//  channel   handshake              word
//  -------   ---------------------  -----------------------------------------
//  input     push / full            position xyz, velocity xyz, point mass
//  result    pop / empty            force xyz, second endpoint flag
//  config    psel penable pwrite    stiffness @0x0, rest length @0x4,
//                                   damping gain @0x8 (32 bit, read back)
//
//  a pair of input words yields two result words, first endpoint then second
//  the back end works on one pair at a time: 15 products (11 when the
//  endpoints coincide) on one bit-serial 66x33 multiplier, a 34-step
//  square root and three 99-step radix-2 divides for d/length
//  reset is synchronous, active low; no clearing pass, the block is ready at once
//  the front takes words while the back works, until the pair queue (two pairs)
//  is full and a first endpoint is held; a finished pair waits in the result stage
// ----------------------------------------------------------------------------
module damped_spring_force
    import dsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [W-1:0]      pwdata,
    output logic [W-1:0]      prdata,
    output logic              pready,
    // endpoint words
    input  logic              push,
    output logic              full,
    input  logic signed [W-1:0] i_position_x,
    input  logic signed [W-1:0] i_position_y,
    input  logic signed [W-1:0] i_position_z,
    input  logic signed [W-1:0] i_velocity_x,
    input  logic signed [W-1:0] i_velocity_y,
    input  logic signed [W-1:0] i_velocity_z,
    input  logic [W-1:0]      i_point_mass,
    // force words
    input  logic              pop,
    output logic              empty,
    output logic signed [W-1:0] o_force_x,
    output logic signed [W-1:0] o_force_y,
    output logic signed [W-1:0] o_force_z,
    output logic              o_second_endpoint
);

    t_cfg      r_cfg;
    t_endpoint item;
    t_pair     front_pair;
    t_pair     q_head;
    t_qflags   q_flags;
    t_result   res;
    logic      q_push;
    logic      q_pop;
    logic      cfg_wr;

    // register file, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stiffness <= W'(1) << FRAC_BITS;
            r_cfg.rest_len  <= W'(1) << FRAC_BITS;
            r_cfg.damping   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_STIFFNESS: r_cfg.stiffness <= pwdata;
                REG_REST_LEN:  r_cfg.rest_len  <= pwdata;
                REG_DAMPING:   r_cfg.damping   <= pwdata;
                default:       ; // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_STIFFNESS: prdata = r_cfg.stiffness;
            REG_REST_LEN:  prdata = r_cfg.rest_len;
            REG_DAMPING:   prdata = r_cfg.damping;
            default:       prdata = '0;
        endcase
    end

    // pack the endpoint word, index 0 is x
    assign item.pos  = {i_position_z, i_position_y, i_position_x};
    assign item.vel  = {i_velocity_z, i_velocity_y, i_velocity_x};
    assign item.mass = i_point_mass;

    dsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_qfull (q_flags.full),
        .o_full  (full),
        .o_qpush (q_push),
        .o_pair  (front_pair)
    );

    dsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pair),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_flags (q_flags)
    );

    dsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_head),
        .i_qflags (q_flags),
        .o_qpop   (q_pop),
        .i_cfg    (r_cfg),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_res    (res)
    );

    assign o_force_x         = res.fx;
    assign o_force_y         = res.fy;
    assign o_force_z         = res.fz;
    assign o_second_endpoint = res.second;

endmodule

[sv/dsf_queue.sv]
// ----------------------------------------------------------------------------
// dsf_queue
// two-entry queue of endpoint pairs between front and back
// ----------------------------------------------------------------------------
module dsf_queue
    import dsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pair   i_data,
    input  logic    i_pop,
    output t_pair   o_head,
    output t_qflags o_flags
);

    t_pair      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign push_ok = i_push && (r_cnt != 2'd2);
    assign pop_ok  = i_pop && (r_cnt != 2'd0);
    assign n_cnt   = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= r_wptr ^ push_ok;
            r_rptr <= r_rptr ^ pop_ok;
            r_cnt  <= n_cnt;
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_flags.full  = (r_cnt == 2'd2);
    assign o_flags.empty = (r_cnt == 2'd0);

endmodule

[sv/dsf_front.sv]
// ----------------------------------------------------------------------------
// dsf_front
// pairs incoming endpoint words, holding the first of each pair
// ----------------------------------------------------------------------------
module dsf_front
    import dsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_endpoint i_item,
    input  logic      i_qfull,
    output logic      o_full,
    output logic      o_qpush,
    output t_pair     o_pair
);

    logic      r_held;
    t_endpoint r_hold;
    logic      accept;

    // a first endpoint can always be taken, a second needs queue room
    assign o_full  = r_held && i_qfull;
    assign accept  = i_push && !o_full;
    assign o_qpush = accept && r_held;
    assign o_pair  = '{e0: r_hold, e1: i_item};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (accept) begin
            r_held <= !r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_held) begin
            r_hold <= i_item;
        end
    end

endmodule

[sv/dsf_mul.sv]
// ----------------------------------------------------------------------------
// dsf_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module dsf_mul
    import dsf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic            o_done,
    output logic [MP_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MB_W);

    logic [MA_W-1:0]  r_a;
    logic [MA_W-1:0]  r_hi;
    logic [MB_W-1:0]  r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MA_W:0]    sum;
    logic             last;

    assign sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MA_W+1){1'b0}});
    assign last = (r_cnt == CNT_W'(MB_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[MA_W:1];
            r_lo <= {sum[0], r_lo[MB_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

[sv/dsf_div.sv]
// ----------------------------------------------------------------------------
// dsf_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dsf_div
    import dsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MP_W-1:0]  i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [MP_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(MP_W);

    logic [MP_W-1:0]  r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             last;

    assign shifted = {r_rem, r_q[MP_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};
    assign last    = (r_cnt == CNT_W'(MP_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_q   <= {r_q[MP_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[sv/dsf_back.sv]
// ----------------------------------------------------------------------------
// dsf_back
// sequencer computing both endpoint forces of one spring, with result stage
// ----------------------------------------------------------------------------
`include "damped_spring_force_macros.svh"

module dsf_back
    import dsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pair   i_job,
    input  t_qflags i_qflags,
    output logic    o_qpop,
    input  t_cfg    i_cfg,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_MWAIT = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DWAIT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [2:0] PH_SQ  = 3'd0;
    localparam logic [2:0] PH_SK  = 3'd1;
    localparam logic [2:0] PH_SPR = 3'd2;
    localparam logic [2:0] PH_CM  = 3'd3;
    localparam logic [2:0] PH_DMP = 3'd4;

    localparam int SQ_CNT_W = $clog2(LEN_W);

    localparam logic signed [TERM_W:0] SAT_HI =
        {{(TERM_W-W+1){1'b0}}, 1'b0, {(W-1){1'b1}}};
    localparam logic signed [TERM_W:0] SAT_LO =
        {{(TERM_W-W+1){1'b1}}, 1'b1, {(W-1){1'b0}}};

    function automatic logic [MAG_W-1:0] f_clamp(input logic [MP_W-1:0] x);
        f_clamp = (x > MP_W'(TERM_CLAMP)) ? TERM_CLAMP : x[MAG_W-1:0];
    endfunction

    function automatic logic signed [TERM_W-1:0] f_sign(input logic [MAG_W-1:0] m,
                                                        input logic neg);
        logic signed [TERM_W-1:0] v;
        v = $signed({1'b0, m});
        f_sign = neg ? -v : v;
    endfunction

    function automatic logic [W-1:0] f_sat(input logic signed [TERM_W:0] s);
        if (s > SAT_HI) begin
            f_sat = SAT_HI[W-1:0];
        end else if (s < SAT_LO) begin
            f_sat = SAT_LO[W-1:0];
        end else begin
            f_sat = s[W-1:0];
        end
    endfunction

    logic [2:0]               r_state;
    logic [2:0]               r_phase;
    logic [1:0]               r_idx;
    logic                     r_end;
    t_pair                    r_job;
    logic [DMAG_W-1:0]        r_dmag [3];
    logic                     r_dneg [3];
    logic [SQ_W-1:0]          r_sq;
    logic [RAD_W-1:0]         r_rad;
    logic [LEN_W-1:0]         r_root;
    logic [REM_W-1:0]         r_rem;
    logic [SQ_CNT_W-1:0]      r_scnt;
    logic [MA_W-1:0]          r_sk;
    logic [TERM_W-1:0]        r_cm;
    logic signed [TERM_W-1:0] r_spring [3];
    logic signed [TERM_W-1:0] r_damp [2][3];
    t_result                  r_res0;
    t_result                  r_res1;
    logic [1:0]               r_out_cnt;

    logic                     mul_start;
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic                     mul_done;
    logic [MP_W-1:0]          mul_prod;
    logic                     div_start;
    logic                     div_done;
    logic [MP_W-1:0]          div_quot;

    logic [DMAG_W-1:0]        dif [3];
    logic [DMAG_W-1:0]        dmag_in [3];
    logic signed [STR_W-1:0]  stretch;
    logic [STR_W-1:0]         stretch_neg;
    logic                     str_neg;
    logic [LEN_W-1:0]         str_mag;
    t_endpoint                cur;
    logic [W-1:0]             vel;
    logic                     v_neg;
    logic [W-1:0]             v_mag;
    logic [SQ_W-1:0]          sq_sum;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         trial;
    logic                     sq_ge;
    logic [LEN_W-1:0]         n_root;
    logic signed [TERM_W-1:0] spr_term;
    logic signed [TERM_W-1:0] dmp_term;
    logic signed [TERM_W:0]   sum0 [3];
    logic signed [TERM_W:0]   sum1 [3];
    logic [W-1:0]             f0 [3];
    logic [W-1:0]             f1 [3];

    // separation vector of the queued pair
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dif[i]     = {i_job.e0.pos[i][W-1], i_job.e0.pos[i]}
                       - {i_job.e1.pos[i][W-1], i_job.e1.pos[i]};
            dmag_in[i] = dif[i][DMAG_W-1] ? (~dif[i] + 1'b1) : dif[i];
        end
    end

    // rest length minus measured length
    assign stretch     = $signed({3'b000, i_cfg.rest_len}) - $signed({1'b0, r_root});
    assign stretch_neg = -stretch;
    assign str_neg     = stretch[STR_W-1];
    assign str_mag     = str_neg ? stretch_neg[LEN_W-1:0] : stretch[LEN_W-1:0];

    assign cur   = r_end ? r_job.e1 : r_job.e0;
    assign vel   = cur.vel[r_idx];
    assign v_neg = vel[W-1];
    assign v_mag = v_neg ? (~vel + 1'b1) : vel;

    assign sq_sum = r_sq + mul_prod[SQ_W-1:0];

    // one digit of the integer square root
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign sq_ge  = (rem_sh >= trial);
    assign n_root = {r_root[LEN_W-2:0], sq_ge};

    assign spr_term = f_sign(f_clamp(div_quot), str_neg ^ r_dneg[r_idx]);
    assign dmp_term = f_sign(f_clamp(mul_prod >> (2 * FRAC_BITS)), !v_neg);

    always_comb begin
        case (r_phase)
            PH_SQ: begin
                mul_a = MA_W'(r_dmag[r_idx]);
                mul_b = r_dmag[r_idx];
            end
            PH_SK: begin
                mul_a = MA_W'(str_mag);
                mul_b = MB_W'(i_cfg.stiffness);
            end
            PH_SPR: begin
                mul_a = r_sk;
                mul_b = r_dmag[r_idx];
            end
            PH_CM: begin
                mul_a = MA_W'(i_cfg.damping);
                mul_b = MB_W'(cur.mass);
            end
            PH_DMP: begin
                mul_a = MA_W'(r_cm);
                mul_b = MB_W'(v_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum0[i] = {r_spring[i][TERM_W-1], r_spring[i]}
                    + {r_damp[0][i][TERM_W-1], r_damp[0][i]};
            sum1[i] = {r_damp[1][i][TERM_W-1], r_damp[1][i]}
                    - {r_spring[i][TERM_W-1], r_spring[i]};
            f0[i]   = f_sat(sum0[i]);
            f1[i]   = f_sat(sum1[i]);
        end
    end

    assign mul_start = (r_state == ST_MUL);
    assign div_start = (r_state == ST_DIV);
    assign o_qpop    = (r_state == ST_IDLE) && !i_qflags.empty;

    dsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    dsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_prod),
        .i_den   ({r_root, {FRAC_BITS{1'b0}}}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_cnt <= 2'd0;
        end else begin
            if (i_pop && (r_out_cnt != 2'd0)) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_qflags.empty) begin
                        r_job <= i_job;
                        for (int i = 0; i < 3; i++) begin
                            r_dmag[i] <= dmag_in[i];
                            r_dneg[i] <= dif[i][DMAG_W-1];
                        end
                        r_sq    <= '0;
                        r_idx   <= 2'd0;
                        r_end   <= 1'b0;
                        r_phase <= PH_SQ;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mul_done) begin
                        case (r_phase)
                            PH_SQ: begin
                                r_sq <= sq_sum;
                                if (r_idx == 2'd2) begin
                                    r_rad   <= RAD_W'(sq_sum);
                                    r_root  <= '0;
                                    r_rem   <= '0;
                                    r_scnt  <= '0;
                                    r_state <= ST_SQRT;
                                end else begin
                                    r_idx   <= r_idx + 2'd1;
                                    r_state <= ST_MUL;
                                end
                            end
                            PH_SK: begin
                                r_sk    <= mul_prod[MA_W-1:0];
                                r_phase <= PH_SPR;
                                r_idx   <= 2'd0;
                                r_state <= ST_MUL;
                            end
                            PH_SPR: begin
                                r_state <= ST_DIV;
                            end
                            PH_CM: begin
                                r_cm    <= mul_prod[TERM_W-1:0];
                                r_phase <= PH_DMP;
                                r_idx   <= 2'd0;
                                r_state <= ST_MUL;
                            end
                            PH_DMP: begin
                                r_damp[r_end][r_idx] <= dmp_term;
                                if (r_idx == 2'd2) begin
                                    if (!r_end) begin
                                        r_end   <= 1'b1;
                                        r_phase <= PH_CM;
                                        r_state <= ST_MUL;
                                    end else begin
                                        r_state <= ST_OUT;
                                    end
                                end else begin
                                    r_idx   <= r_idx + 2'd1;
                                    r_state <= ST_MUL;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    r_rem  <= sq_ge ? (rem_sh - trial) : rem_sh;
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == SQ_CNT_W'(LEN_W - 1)) begin
                        r_idx   <= 2'd0;
                        r_end   <= 1'b0;
                        r_state <= ST_MUL;
                        if (n_root == '0) begin
                            // coincident endpoints: damping only
                            for (int i = 0; i < 3; i++) begin
                                r_spring[i] <= '0;
                            end
                            r_phase <= PH_CM;
                        end else begin
                            r_phase <= PH_SK;
                        end
                    end
                end
                ST_DIV: begin
                    r_state <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        r_spring[r_idx] <= spr_term;
                        if (r_idx == 2'd2) begin
                            r_phase <= PH_CM;
                            r_idx   <= 2'd0;
                            r_end   <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (r_out_cnt == 2'd0) begin
                        r_res0    <= '{fx: f0[0], fy: f0[1], fz: f0[2], second: 1'b0};
                        r_res1    <= '{fx: f1[0], fy: f1[1], fz: f1[2], second: 1'b1};
                        r_out_cnt <= 2'd2;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty = (r_out_cnt == 2'd0);
    assign o_res   = (r_out_cnt == 2'd2) ? r_res0 : r_res1;

    `DSF_ASSERT_IMP(a_mul_done_in_wait, i_clk, i_rst_n, mul_done, r_state == ST_MWAIT, "multiplier finished outside its wait state")
    `DSF_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == ST_DWAIT, "divider finished outside its wait state")
    `DSF_ASSERT_NXT(a_out_load, i_clk, i_rst_n, (r_state == ST_OUT) && (r_out_cnt == 2'd0), (r_out_cnt == 2'd2) && (r_state == ST_IDLE), "result pair not loaded into empty stage")

endmodule
